### design/bcc_pkg.sv
`default_nettype none

package bcc_pkg;

  // Default number of fraction bits of every fixed-point value.
  localparam int FRAC_BITS_DEF = 16;

  // Fixed widths of the interface fields.
  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int ROT_W   = 18;

endpackage

`default_nettype wire

### design/box_circle_contact_top.sv
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   box pose, half extents, rotation, circle
// out_      output     out_valid / out_ready hit, normal, penetration, contact points
//
// Every pair passes 8 + 31 + (F + 1) + 6 = 62 register stages at the default of 16 fraction
// bits. The 31 square-root steps and the F + 1 division steps, one per stage, set that depth.
// One pair enters per cycle while the output is not stalled. Reset clears only the valid bits
// of the stages. A stall at the output freezes the whole pipeline at once, so nothing is lost
// or repeated.

`default_nettype none

module box_circle_contact_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [bcc_pkg::COORD_W-1:0]   in_box_center_x,
  input  wire logic signed [bcc_pkg::COORD_W-1:0]   in_box_center_y,
  input  wire logic        [bcc_pkg::EXT_W-1:0]     in_box_half_x,
  input  wire logic        [bcc_pkg::EXT_W-1:0]     in_box_half_y,
  input  wire logic signed [bcc_pkg::ROT_W-1:0]     in_rot_xx,
  input  wire logic signed [bcc_pkg::ROT_W-1:0]     in_rot_xy,
  input  wire logic signed [bcc_pkg::ROT_W-1:0]     in_rot_yx,
  input  wire logic signed [bcc_pkg::ROT_W-1:0]     in_rot_yy,
  input  wire logic signed [bcc_pkg::COORD_W-1:0]   in_circle_center_x,
  input  wire logic signed [bcc_pkg::COORD_W-1:0]   in_circle_center_y,
  input  wire logic        [bcc_pkg::EXT_W-1:0]     in_circle_radius,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_hit,
  output logic signed [bcc_pkg::ROT_W-1:0]          out_normal_x,
  output logic signed [bcc_pkg::ROT_W-1:0]          out_normal_y,
  output logic        [bcc_pkg::EXT_W-1:0]          out_penetration,
  output logic signed [bcc_pkg::COORD_W-1:0]        out_box_point_x,
  output logic signed [bcc_pkg::COORD_W-1:0]        out_box_point_y,
  output logic signed [bcc_pkg::COORD_W-1:0]        out_circle_point_x,
  output logic signed [bcc_pkg::COORD_W-1:0]        out_circle_point_y
);

  localparam int F    = bcc_pkg::FRAC_BITS_DEF;
  // Normal in local space: up to +/- ONE plus a sign bit.
  localparam int NW   = F + 2;
  // Width of the sum of two rotation products of the center offset.
  localparam int SW   = 53;
  // Local center coordinates before classification.
  localparam int LXW  = (SW - F > 35) ? SW - F : 35;
  // Local contact coordinates once the pair is known to touch.
  localparam int LC   = 34;
  localparam int SQN  = 31;
  localparam int DVN  = F + 1;
  localparam int PRW  = NW + 32;
  localparam int NPW  = NW + 18;
  localparam int NSW  = NPW + 1;
  localparam int NRW  = NSW - F;
  localparam int NCW  = F + 22;
  localparam int PPW  = 52;
  localparam int PTW  = 60;
  localparam int PRW2 = PTW - F;
  localparam int NST  = 8 + SQN + DVN + 6;

  localparam logic signed [SW-1:0]   HALF_S  = SW'(1) << (F - 1);
  localparam logic signed [PRW-1:0]  HALF_P  = PRW'(1) << (F - 1);
  localparam logic signed [NSW-1:0]  HALF_N  = NSW'(1) << (F - 1);
  localparam logic signed [PTW-1:0]  HALF_T  = PTW'(1) << (F - 1);
  localparam logic signed [NW-1:0]   ONE_N   = NW'(1) << F;
  localparam logic signed [NCW-1:0]  ONE_C   = NCW'(1) << F;
  localparam logic signed [PRW2-1:0] PT_MAX  = PRW2'(64'sh7FFFFFFF);
  localparam logic signed [PRW2-1:0] PT_MIN  = -PT_MAX - PRW2'(1);

  typedef struct packed {
    logic signed [17:0] rxx;
    logic signed [17:0] rxy;
    logic signed [17:0] ryx;
    logic signed [17:0] ryy;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        r;
  } geo_t;

  // Everything a pair needs after classification; deep-case results are final here,
  // shallow-case fields are completed once the distance and the normal are known.
  typedef struct packed {
    geo_t                 geo;
    logic                 deep;
    logic                 hit;
    logic [31:0]          pen;
    logic signed [NW-1:0] nx;
    logic signed [NW-1:0] ny;
    logic signed [LC-1:0] blx;
    logic signed [LC-1:0] bly;
    logic signed [LC-1:0] clx;
    logic signed [LC-1:0] cly;
    logic                 sgx;
    logic                 sgy;
    logic [30:0]          aex;
    logic [30:0]          aey;
  } late_t;

  logic           en;
  logic [NST-1:0] vld_r;

  // The whole pipeline moves when the output register is empty or being taken.
  assign en        = !vld_r[NST-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // Stage 1: offset of the circle center from the box center.
  geo_t               geo1_r;
  logic [30:0]        hx1_r, hy1_r;
  logic signed [32:0] dx1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      geo1_r <= '{rxx: in_rot_xx, rxy: in_rot_xy, ryx: in_rot_yx, ryy: in_rot_yy,
                  bx: in_box_center_x, by: in_box_center_y, r: in_circle_radius};
      hx1_r  <= in_box_half_x;
      hy1_r  <= in_box_half_y;
      dx1_r  <= 33'(in_circle_center_x) - 33'(in_box_center_x);
      dy1_r  <= 33'(in_circle_center_y) - 33'(in_box_center_y);
    end
  end

  // Stage 2: the four products of the transposed rotation.
  geo_t               geo2_r;
  logic [30:0]        hx2_r, hy2_r;
  logic signed [50:0] pxx2_r, pyx2_r, pxy2_r, pyy2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      geo2_r <= geo1_r;
      hx2_r  <= hx1_r;
      hy2_r  <= hy1_r;
      pxx2_r <= geo1_r.rxx * dx1_r;
      pyx2_r <= geo1_r.ryx * dy1_r;
      pxy2_r <= geo1_r.rxy * dx1_r;
      pyy2_r <= geo1_r.ryy * dy1_r;
    end
  end

  // Stage 3: rounded local center.
  geo_t                geo3_r;
  logic [30:0]         hx3_r, hy3_r;
  logic signed [LXW-1:0] lx3_r, ly3_r;
  logic signed [SW-1:0]  sumx3, sumy3;

  always_comb begin
    sumx3 = SW'(pxx2_r) + SW'(pyx2_r) + HALF_S;
    sumy3 = SW'(pxy2_r) + SW'(pyy2_r) + HALF_S;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo3_r <= geo2_r;
      hx3_r  <= hx2_r;
      hy3_r  <= hy2_r;
      lx3_r  <= LXW'($signed(sumx3[SW-1:F]));
      ly3_r  <= LXW'($signed(sumy3[SW-1:F]));
    end
  end

  // Stage 4: magnitudes and the clamp of the center onto the box.
  geo_t                  geo4_r;
  logic [30:0]           hx4_r, hy4_r;
  logic signed [LXW-1:0] lx4_r, ly4_r;
  logic [LXW-1:0]        alx4_r, aly4_r;
  logic signed [31:0]    px4_r, py4_r;
  logic signed [LXW-1:0] hxe4, hye4;
  logic signed [31:0]    px4_nxt, py4_nxt;

  always_comb begin
    hxe4 = $signed(LXW'(hx3_r));
    hye4 = $signed(LXW'(hy3_r));
    if (lx3_r > hxe4) begin
      px4_nxt = $signed({1'b0, hx3_r});
    end else if (lx3_r < -hxe4) begin
      px4_nxt = -$signed({1'b0, hx3_r});
    end else begin
      px4_nxt = lx3_r[31:0];
    end
    if (ly3_r > hye4) begin
      py4_nxt = $signed({1'b0, hy3_r});
    end else if (ly3_r < -hye4) begin
      py4_nxt = -$signed({1'b0, hy3_r});
    end else begin
      py4_nxt = ly3_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo4_r <= geo3_r;
      hx4_r  <= hx3_r;
      hy4_r  <= hy3_r;
      lx4_r  <= lx3_r;
      ly4_r  <= ly3_r;
      alx4_r <= lx3_r[LXW-1] ? LXW'(-lx3_r) : LXW'(lx3_r);
      aly4_r <= ly3_r[LXW-1] ? LXW'(-ly3_r) : LXW'(ly3_r);
      px4_r  <= px4_nxt;
      py4_r  <= py4_nxt;
    end
  end

  // Stage 5: inside test, distances to the faces, and the offset from the clamped point.
  geo_t                  geo5_r;
  logic                  deep5_r;
  logic [30:0]           sx5_r, sy5_r;
  logic signed [LXW-1:0] ex5_r, ey5_r;
  logic signed [LC-1:0]  lx5_r, ly5_r;
  logic signed [31:0]    px5_r, py5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      geo5_r  <= geo4_r;
      deep5_r <= (alx4_r <= LXW'(hx4_r)) && (aly4_r <= LXW'(hy4_r));
      sx5_r   <= hx4_r - alx4_r[30:0];
      sy5_r   <= hy4_r - aly4_r[30:0];
      ex5_r   <= lx4_r - LXW'(px4_r);
      ey5_r   <= ly4_r - LXW'(py4_r);
      lx5_r   <= lx4_r[LC-1:0];
      ly5_r   <= ly4_r[LC-1:0];
      px5_r   <= px4_r;
      py5_r   <= py4_r;
    end
  end

  // Stage 6: deep-case results are finished here. The y axis wins a tie.
  late_t                 c6_r, c6_nxt;
  logic                  far6_r, far6_nxt;
  logic [LXW-1:0]        aex6, aey6;
  logic                  usey6;
  logic signed [LC-1:0]  r34, sx34, sy34;
  logic signed [LC-1:0]  dbx6, dby6, dcx6, dcy6;
  logic signed [NW-1:0]  dnx6, dny6;

  always_comb begin
    aex6     = ex5_r[LXW-1] ? LXW'(-ex5_r) : LXW'(ex5_r);
    aey6     = ey5_r[LXW-1] ? LXW'(-ey5_r) : LXW'(ey5_r);
    far6_nxt = (aex6 > LXW'(geo5_r.r)) || (aey6 > LXW'(geo5_r.r));
    usey6    = sy5_r <= sx5_r;
    r34      = $signed({3'b000, geo5_r.r});
    sx34     = $signed({3'b000, sx5_r});
    sy34     = $signed({3'b000, sy5_r});
    dnx6     = '0;
    dny6     = '0;
    dbx6     = lx5_r;
    dby6     = ly5_r;
    dcx6     = lx5_r;
    dcy6     = ly5_r;
    if (usey6) begin
      if (ly5_r[LC-1]) begin
        dny6 = -ONE_N;
        dcy6 = ly5_r + r34;
        dby6 = ly5_r - sy34;
      end else begin
        dny6 = ONE_N;
        dcy6 = ly5_r - r34;
        dby6 = ly5_r + sy34;
      end
    end else begin
      if (lx5_r[LC-1]) begin
        dnx6 = -ONE_N;
        dcx6 = lx5_r + r34;
        dbx6 = lx5_r - sx34;
      end else begin
        dnx6 = ONE_N;
        dcx6 = lx5_r - r34;
        dbx6 = lx5_r + sx34;
      end
    end
    c6_nxt      = '0;
    c6_nxt.geo  = geo5_r;
    c6_nxt.deep = deep5_r;
    c6_nxt.pen  = {1'b0, geo5_r.r} + {1'b0, usey6 ? sy5_r : sx5_r};
    c6_nxt.nx   = dnx6;
    c6_nxt.ny   = dny6;
    c6_nxt.blx  = deep5_r ? dbx6 : LC'(px5_r);
    c6_nxt.bly  = deep5_r ? dby6 : LC'(py5_r);
    // A shallow pair starts its circle point from the local center.
    c6_nxt.clx  = deep5_r ? dcx6 : lx5_r;
    c6_nxt.cly  = deep5_r ? dcy6 : ly5_r;
    c6_nxt.sgx  = ex5_r[LXW-1];
    c6_nxt.sgy  = ey5_r[LXW-1];
    c6_nxt.aex  = aex6[30:0];
    c6_nxt.aey  = aey6[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6_r   <= c6_nxt;
      far6_r <= far6_nxt;
    end
  end

  // Stage 7: squares.
  late_t       c7_r;
  logic        far7_r;
  logic [61:0] ex2_7_r, ey2_7_r, r2_7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c7_r    <= c6_r;
      far7_r  <= far6_r;
      ex2_7_r <= c6_r.aex * c6_r.aex;
      ey2_7_r <= c6_r.aey * c6_r.aey;
      r2_7_r  <= c6_r.geo.r * c6_r.geo.r;
    end
  end

  // Stage 8: squared distance and the final hit decision. Its registers are the
  // first entries of the square-root pipeline.
  late_t       sq_c_r   [SQN+1];
  logic [63:0] sq_rem_r [SQN+1];
  logic [30:0] sq_q_r   [SQN+1];
  logic [62:0] d2_8;
  late_t       c8_nxt;

  always_comb begin
    d2_8       = {1'b0, ex2_7_r} + {1'b0, ey2_7_r};
    c8_nxt     = c7_r;
    c8_nxt.hit = c7_r.deep || (!far7_r && (d2_8 <= {1'b0, r2_7_r}));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c_r[0]     <= c8_nxt;
      sq_rem_r[0]   <= {1'b0, d2_8};
      sq_q_r[0]     <= '0;
    end
  end

  // Floor square root, one result bit per stage from the top.
  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam int B = SQN - 1 - k;
    logic [63:0] trial;
    logic [63:0] rem_nxt;
    logic [30:0] q_nxt;

    always_comb begin
      trial   = (64'(sq_q_r[k]) << (B + 1)) + (64'(1) << (2 * B));
      rem_nxt = sq_rem_r[k];
      q_nxt   = sq_q_r[k];
      if (sq_rem_r[k] >= trial) begin
        rem_nxt  = sq_rem_r[k] - trial;
        q_nxt[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c_r[k+1]   <= sq_c_r[k];
        sq_rem_r[k+1] <= rem_nxt;
        sq_q_r[k+1]   <= q_nxt;
      end
    end
  end

  // Restoring division |e| * ONE / dist for both axes, one quotient bit per stage.
  late_t       dv_c_r    [DVN];
  logic [32:0] dv_rx_r   [DVN];
  logic [32:0] dv_ry_r   [DVN];
  logic [F:0]  dv_qx_r   [DVN];
  logic [F:0]  dv_qy_r   [DVN];
  logic [30:0] dv_dist_r [DVN];

  for (genvar j = 0; j < DVN; j++) begin : g_div
    localparam int QB = F - j;
    late_t       c_in;
    logic [32:0] rx_in, ry_in, rx_nxt, ry_nxt;
    logic [F:0]  qx_in, qy_in, qx_nxt, qy_nxt;
    logic [30:0] dist_in;

    if (j == 0) begin : g_src
      assign c_in    = sq_c_r[SQN];
      assign dist_in = (sq_q_r[SQN] == '0) ? 31'd1 : sq_q_r[SQN];
      assign rx_in   = {2'b00, sq_c_r[SQN].aex};
      assign ry_in   = {2'b00, sq_c_r[SQN].aey};
      assign qx_in   = '0;
      assign qy_in   = '0;
    end else begin : g_src
      assign c_in    = dv_c_r[j-1];
      assign dist_in = dv_dist_r[j-1];
      assign rx_in   = {dv_rx_r[j-1][31:0], 1'b0};
      assign ry_in   = {dv_ry_r[j-1][31:0], 1'b0};
      assign qx_in   = dv_qx_r[j-1];
      assign qy_in   = dv_qy_r[j-1];
    end

    always_comb begin
      rx_nxt = rx_in;
      ry_nxt = ry_in;
      qx_nxt = qx_in;
      qy_nxt = qy_in;
      if (rx_in >= {2'b00, dist_in}) begin
        rx_nxt     = rx_in - {2'b00, dist_in};
        qx_nxt[QB] = 1'b1;
      end
      if (ry_in >= {2'b00, dist_in}) begin
        ry_nxt     = ry_in - {2'b00, dist_in};
        qy_nxt[QB] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_c_r[j]    <= c_in;
        dv_dist_r[j] <= dist_in;
        dv_rx_r[j]   <= rx_nxt;
        dv_ry_r[j]   <= ry_nxt;
        dv_qx_r[j]   <= qx_nxt;
        dv_qy_r[j]   <= qy_nxt;
      end
    end
  end

  // Late stage 1: signed shallow normal and penetration.
  late_t                l1_r, l1_nxt;
  logic signed [NW-1:0] qxs, qys;

  always_comb begin
    qxs    = $signed({1'b0, dv_qx_r[DVN-1]});
    qys    = $signed({1'b0, dv_qy_r[DVN-1]});
    l1_nxt = dv_c_r[DVN-1];
    if (!l1_nxt.deep) begin
      l1_nxt.nx  = l1_nxt.sgx ? -qxs : qxs;
      l1_nxt.ny  = l1_nxt.sgy ? -qys : qys;
      l1_nxt.pen = {1'b0, l1_nxt.geo.r} - {1'b0, dv_dist_r[DVN-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r <= l1_nxt;
    end
  end

  // Late stage 2: normal times radius.
  late_t                l2_r;
  logic signed [PRW-1:0] nrx2_r, nry2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      l2_r   <= l1_r;
      nrx2_r <= l1_r.nx * $signed({1'b0, l1_r.geo.r});
      nry2_r <= l1_r.ny * $signed({1'b0, l1_r.geo.r});
    end
  end

  // Late stage 3: shallow circle point and saturated penetration.
  late_t                 l3_r, l3_nxt;
  logic [30:0]           pen3_r;
  logic signed [PRW-1:0] rsx3, rsy3;

  always_comb begin
    rsx3   = nrx2_r + HALF_P;
    rsy3   = nry2_r + HALF_P;
    l3_nxt = l2_r;
    if (!l2_r.deep) begin
      l3_nxt.clx = l2_r.clx - $signed(rsx3[PRW-1:F]);
      l3_nxt.cly = l2_r.cly - $signed(rsy3[PRW-1:F]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l3_r     <= l3_nxt;
      pen3_r   <= l2_r.pen[31] ? '1 : l2_r.pen[30:0];
    end
  end

  // Late stage 4: rotation back to world space, twelve products.
  logic                  hit4_r;
  logic [30:0]           pen4_r;
  logic signed [31:0]    bx4_r, by4_r;
  logic signed [NPW-1:0] nxa4_r, nxb4_r, nya4_r, nyb4_r;
  logic signed [PPW-1:0] bxa4_r, bxb4_r, bya4_r, byb4_r;
  logic signed [PPW-1:0] cxa4_r, cxb4_r, cya4_r, cyb4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hit4_r <= l3_r.hit;
      pen4_r <= pen3_r;
      bx4_r  <= l3_r.geo.bx;
      by4_r  <= l3_r.geo.by;
      nxa4_r <= l3_r.geo.rxx * l3_r.nx;
      nxb4_r <= l3_r.geo.rxy * l3_r.ny;
      nya4_r <= l3_r.geo.ryx * l3_r.nx;
      nyb4_r <= l3_r.geo.ryy * l3_r.ny;
      bxa4_r <= l3_r.geo.rxx * l3_r.blx;
      bxb4_r <= l3_r.geo.rxy * l3_r.bly;
      bya4_r <= l3_r.geo.ryx * l3_r.blx;
      byb4_r <= l3_r.geo.ryy * l3_r.bly;
      cxa4_r <= l3_r.geo.rxx * l3_r.clx;
      cxb4_r <= l3_r.geo.rxy * l3_r.cly;
      cya4_r <= l3_r.geo.ryx * l3_r.clx;
      cyb4_r <= l3_r.geo.ryy * l3_r.cly;
    end
  end

  // Late stage 5: sums with rounding. The box center, shifted up by the fraction
  // bits, joins the sum before the rounding shift, which gives the same result as
  // adding it afterwards.
  logic                   hit5_r;
  logic [30:0]            pen5_r;
  logic signed [NRW-1:0]  nx5_r, ny5_r;
  logic signed [PRW2-1:0] bpx5_r, bpy5_r, cpx5_r, cpy5_r;
  logic signed [NSW-1:0]  nsx5, nsy5;
  logic signed [PTW-1:0]  cxo5, cyo5, sbx5, sby5, scx5, scy5;

  always_comb begin
    nsx5 = NSW'(nxa4_r) + NSW'(nxb4_r) + HALF_N;
    nsy5 = NSW'(nya4_r) + NSW'(nyb4_r) + HALF_N;
    cxo5 = (PTW'(bx4_r) <<< F) + HALF_T;
    cyo5 = (PTW'(by4_r) <<< F) + HALF_T;
    sbx5 = PTW'(bxa4_r) + PTW'(bxb4_r) + cxo5;
    sby5 = PTW'(bya4_r) + PTW'(byb4_r) + cyo5;
    scx5 = PTW'(cxa4_r) + PTW'(cxb4_r) + cxo5;
    scy5 = PTW'(cya4_r) + PTW'(cyb4_r) + cyo5;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit5_r <= hit4_r;
      pen5_r <= pen4_r;
      nx5_r  <= $signed(nsx5[NSW-1:F]);
      ny5_r  <= $signed(nsy5[NSW-1:F]);
      bpx5_r <= $signed(sbx5[PTW-1:F]);
      bpy5_r <= $signed(sby5[PTW-1:F]);
      cpx5_r <= $signed(scx5[PTW-1:F]);
      cpy5_r <= $signed(scy5[PTW-1:F]);
    end
  end

  // Late stage 6: clamp the normal to one, saturate the points, and zero a miss.
  logic                   out_hit_r;
  logic signed [17:0]     out_nx_r, out_ny_r;
  logic [30:0]            out_pen_r;
  logic signed [31:0]     out_bpx_r, out_bpy_r, out_cpx_r, out_cpy_r;
  logic signed [NCW-1:0]  nxe6, nye6, nxc6, nyc6;

  function automatic logic signed [31:0] sat_pt(input logic signed [PRW2-1:0] v);
    logic signed [31:0] res;
    if (v > PT_MAX) begin
      res = 32'sh7FFFFFFF;
    end else if (v < PT_MIN) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  always_comb begin
    nxe6 = NCW'(nx5_r);
    nye6 = NCW'(ny5_r);
    nxc6 = (nxe6 > ONE_C) ? ONE_C : ((nxe6 < -ONE_C) ? -ONE_C : nxe6);
    nyc6 = (nye6 > ONE_C) ? ONE_C : ((nye6 < -ONE_C) ? -ONE_C : nye6);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= hit5_r;
      if (hit5_r) begin
        out_nx_r  <= nxc6[17:0];
        out_ny_r  <= nyc6[17:0];
        out_pen_r <= pen5_r;
        out_bpx_r <= sat_pt(bpx5_r);
        out_bpy_r <= sat_pt(bpy5_r);
        out_cpx_r <= sat_pt(cpx5_r);
        out_cpy_r <= sat_pt(cpy5_r);
      end else begin
        out_nx_r  <= '0;
        out_ny_r  <= '0;
        out_pen_r <= '0;
        out_bpx_r <= '0;
        out_bpy_r <= '0;
        out_cpx_r <= '0;
        out_cpy_r <= '0;
      end
    end
  end

  assign out_hit            = out_hit_r;
  assign out_normal_x       = out_nx_r;
  assign out_normal_y       = out_ny_r;
  assign out_penetration    = out_pen_r;
  assign out_box_point_x    = out_bpx_r;
  assign out_box_point_y    = out_bpy_r;
  assign out_circle_point_x = out_cpx_r;
  assign out_circle_point_y = out_cpy_r;

endmodule

`default_nettype wire
